// ----- hdl/teq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types, sizes and helpers for the time ordered event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 7;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_READ,
      S_INS_CMP,
      S_INS_PLACE
   } state_type;

   typedef struct packed {
      logic        [31:0] sec;
      logic        [19:0] usec;
      logic        [15:0] node;
      logic        [4:0]  kind;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic addr_type addr_inc(input addr_type p);
      addr_type r;
      if (p == addr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + addr_type'(1);
      end
      return r;
   endfunction

   function automatic addr_type addr_dec(input addr_type p);
      addr_type r;
      if (p == '0) begin
         r = addr_type'(DEPTH - 1);
      end else begin
         r = p - addr_type'(1);
      end
      return r;
   endfunction

   // base plus an offset below DEPTH, wrapped around the ring
   function automatic addr_type addr_add(input addr_type base, input count_type off);
      logic [ADDR_W:0] s;
      s = {1'b0, base} + (ADDR_W + 1)'(off);
      if (s >= (ADDR_W + 1)'(DEPTH)) begin
         s = s - (ADDR_W + 1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

// ----- hdl/teq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_req_if / teq_rsp_if
// Valid/ready channels for queue commands and their results.
// ----------------------------------------------------------------------------
interface teq_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic        [31:0] stamp_sec;
   logic        [19:0] stamp_usec;
   logic        [15:0] source_node;
   logic        [4:0]  event_kind;
   logic signed [31:0] word_a;
   logic signed [31:0] word_b;
   logic signed [31:0] word_c;
   logic signed [31:0] word_d;

   modport source (output valid, cmd, stamp_sec, stamp_usec, source_node, event_kind,
                   word_a, word_b, word_c, word_d, input ready);
   modport sink   (input valid, cmd, stamp_sec, stamp_usec, source_node, event_kind,
                   word_a, word_b, word_c, word_d, output ready);
endinterface

interface teq_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  status;
   logic        [31:0] out_sec;
   logic        [19:0] out_usec;
   logic        [15:0] out_node;
   logic        [4:0]  out_kind;
   logic signed [31:0] out_a;
   logic signed [31:0] out_b;
   logic signed [31:0] out_c;
   logic signed [31:0] out_d;
   logic        [6:0]  occupancy;

   modport source (output valid, status, out_sec, out_usec, out_node, out_kind,
                   out_a, out_b, out_c, out_d, occupancy, input ready);
   modport sink   (input valid, status, out_sec, out_usec, out_node, out_kind,
                   out_a, out_b, out_c, out_d, occupancy, output ready);
endinterface

// ----- hdl/teq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/time_ordered_event_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Timestamp sorted event queue kept in a ring buffer with insertion by shifting.
// ----------------------------------------------------------------------------
// Events sit in one RAM used as a ring, earliest at the head pointer. A pop
// reads the head. An insert walks back from the tail through one 52-bit time
// comparator, moving each later event up one slot per cycle, and writes the
// new event in S_INS_CMP or, when it is the earliest, in S_INS_PLACE. Inserts
// into an empty queue, full inserts and pops on an empty queue answer straight
// from idle. The single RAM write port sets the pace of the shift. Equal times
// keep arrival order. One command is in progress at a time; req_ch.ready is
// low while it runs and while an untaken result is held.
module time_ordered_event_queue (
   input  logic clock,
   input  logic reset,
   teq_req_if.sink   req_ch,
   teq_rsp_if.source rsp_ch
);

   teq_pkg::state_type  state_ff, state_in;
   teq_pkg::addr_type   head_ff, head_in;
   teq_pkg::addr_type   cur_ff, cur_in;
   teq_pkg::addr_type   dst_ff, dst_in;
   teq_pkg::count_type  count_ff, count_in;
   teq_pkg::count_type  left_ff, left_in;
   teq_pkg::entry_type  item_ff, item_in;

   logic                rsp_valid_ff, rsp_valid_in;
   teq_pkg::status_type rsp_status_ff, rsp_status_in;
   teq_pkg::entry_type  rsp_entry_ff, rsp_entry_in;
   logic [teq_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic                wr_en;
   teq_pkg::addr_type   wr_addr;
   teq_pkg::entry_type  wr_data;
   logic                rd_en;
   teq_pkg::addr_type   rd_addr;
   teq_pkg::entry_type  rd_data;
   logic [teq_pkg::ENTRY_W-1:0] rd_bits;

   teq_pkg::entry_type  new_entry;
   logic                slot_free;
   logic                accept;
   logic                is_pop;
   logic                is_empty;
   logic                is_full;
   logic                later;

   assign new_entry = '{sec: req_ch.stamp_sec, usec: req_ch.stamp_usec,
                        node: req_ch.source_node, kind: req_ch.event_kind,
                        a: req_ch.word_a, b: req_ch.word_b,
                        c: req_ch.word_c, d: req_ch.word_d};

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == teq_pkg::S_IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_pop       = (req_ch.cmd == teq_pkg::CMD_POP);
   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff == teq_pkg::count_type'(teq_pkg::DEPTH));
   assign rd_data      = teq_pkg::entry_type'(rd_bits);

   // stored event strictly later than the one being inserted
   assign later = {rd_data.sec, rd_data.usec} > {item_ff.sec, item_ff.usec};

   teq_ram #(
      .WIDTH (teq_pkg::ENTRY_W),
      .DEPTH (teq_pkg::DEPTH),
      .ADDR_W(teq_pkg::ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         teq_pkg::S_IDLE: begin
            if (accept) begin
               if (is_pop) begin
                  state_in = is_empty ? teq_pkg::S_IDLE : teq_pkg::S_POP_READ;
               end else begin
                  state_in = (is_full || is_empty) ? teq_pkg::S_IDLE : teq_pkg::S_INS_CMP;
               end
            end
         end
         teq_pkg::S_POP_READ: state_in = teq_pkg::S_IDLE;
         teq_pkg::S_INS_CMP: begin
            if (!later) begin
               state_in = teq_pkg::S_IDLE;
            end else if (left_ff == teq_pkg::count_type'(1)) begin
               state_in = teq_pkg::S_INS_PLACE;
            end
         end
         teq_pkg::S_INS_PLACE: state_in = teq_pkg::S_IDLE;
         default: state_in = teq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in       = head_ff;
      cur_in        = cur_ff;
      dst_in        = dst_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      item_in       = item_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = item_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      case (state_ff)
         teq_pkg::S_IDLE: begin
            if (accept) begin
               if (is_pop) begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = teq_pkg::ST_EMPTY;
                     rsp_entry_in  = '0;
                     rsp_occ_in    = teq_pkg::OCC_W'(count_ff);
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = head_ff;
                  end
               end else if (is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = teq_pkg::ST_FULL;
                  rsp_entry_in  = '0;
                  rsp_occ_in    = teq_pkg::OCC_W'(count_ff);
               end else if (is_empty) begin
                  wr_en         = 1'b1;
                  wr_addr       = head_ff;
                  wr_data       = new_entry;
                  count_in      = teq_pkg::count_type'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = teq_pkg::ST_INSERTED;
                  rsp_entry_in  = '0;
                  rsp_occ_in    = teq_pkg::OCC_W'(1);
               end else begin
                  // start at the last stored event and walk toward the head
                  rd_en   = 1'b1;
                  rd_addr = teq_pkg::addr_add(head_ff, count_ff - teq_pkg::count_type'(1));
                  cur_in  = rd_addr;
                  dst_in  = teq_pkg::addr_inc(rd_addr);
                  left_in = count_ff;
                  item_in = new_entry;
               end
            end
         end
         teq_pkg::S_POP_READ: begin
            head_in       = teq_pkg::addr_inc(head_ff);
            count_in      = count_ff - teq_pkg::count_type'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = teq_pkg::ST_POPPED;
            rsp_entry_in  = rd_data;
            rsp_occ_in    = teq_pkg::OCC_W'(count_ff - teq_pkg::count_type'(1));
         end
         teq_pkg::S_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            if (later) begin
               wr_data = rd_data;
               dst_in  = cur_ff;
               if (left_ff != teq_pkg::count_type'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = teq_pkg::addr_dec(cur_ff);
                  cur_in  = rd_addr;
                  left_in = left_ff - teq_pkg::count_type'(1);
               end else if (cur_ff == head_ff) begin
                  // new event becomes the earliest, head slot stays put
                  head_in = head_ff;
               end
            end else begin
               wr_data       = item_ff;
               count_in      = count_ff + teq_pkg::count_type'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = teq_pkg::ST_INSERTED;
               rsp_entry_in  = '0;
               rsp_occ_in    = teq_pkg::OCC_W'(count_ff + teq_pkg::count_type'(1));
            end
         end
         teq_pkg::S_INS_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = dst_ff;
            wr_data       = item_ff;
            count_in      = count_ff + teq_pkg::count_type'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = teq_pkg::ST_INSERTED;
            rsp_entry_in  = '0;
            rsp_occ_in    = teq_pkg::OCC_W'(count_ff + teq_pkg::count_type'(1));
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= teq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      item_ff       <= item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.out_sec   = rsp_entry_ff.sec;
   assign rsp_ch.out_usec  = rsp_entry_ff.usec;
   assign rsp_ch.out_node  = rsp_entry_ff.node;
   assign rsp_ch.out_kind  = rsp_entry_ff.kind;
   assign rsp_ch.out_a     = rsp_entry_ff.a;
   assign rsp_ch.out_b     = rsp_entry_ff.b;
   assign rsp_ch.out_c     = rsp_entry_ff.c;
   assign rsp_ch.out_d     = rsp_entry_ff.d;
   assign rsp_ch.occupancy = rsp_occ_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= teq_pkg::count_type'(teq_pkg::DEPTH))
      else $error("fill count above depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_status_ff))
      else $error("pending result overwritten");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == teq_pkg::S_POP_READ || state_ff == teq_pkg::S_INS_CMP ||
       state_ff == teq_pkg::S_INS_PLACE) |-> !rsp_valid_ff)
      else $error("result held while a command is in progress");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == teq_pkg::S_POP_READ |=> count_ff == $past(count_ff) - teq_pkg::count_type'(1))
      else $error("pop did not shrink the queue");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for time_ordered_event_queue. A clocked driver sends
// insert and pop commands from a prebuilt list, and a shadow sorted list
// predicts status, popped event and occupancy for every accepted command.
// A clocked monitor checks each result in order.
// The stimulus has a short directed opening: pop on empty, ties, a new
// earliest event, extreme stamps and microseconds past one million. Random
// phases follow that fill the queue past full, drain it past empty, or mix
// both. Both sides idle at random, and the result side holds off once for
// a long stretch so that the queue stalls its input.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_COMMANDS = 800;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int HOLD_CYCLES     = 600;
   localparam int HOLD_AFTER      = 250;
   localparam int DRAIN_CYCLES    = 2 * teq_pkg::DEPTH + 8;

   typedef struct {
      teq_pkg::cmd_type   cmd;
      teq_pkg::entry_type ev;
   } queue_command_type;

   typedef struct {
      teq_pkg::status_type       status;
      teq_pkg::entry_type        ev;
      logic [teq_pkg::OCC_W-1:0] occupancy;
   } queue_result_type;

   logic clock;
   logic reset;

   teq_req_if req_bus ();
   teq_rsp_if rsp_bus ();

   time_ordered_event_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   queue_command_type  pending_commands[$];
   queue_result_type   awaited_results[$];
   teq_pkg::entry_type sorted_events[$];

   int total_commands  = 0;
   int words_accepted  = 0;
   int results_seen    = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int send_gap_left   = 0;
   int recv_stall_left = 0;
   int gen_fill        = 0;
   int hold_count      = 0;
   logic hold_off      = 1'b0;
   logic hold_done     = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // shadow of the queue: stable sorted insert, pop from the head
   function automatic queue_result_type predict_queue_result(queue_command_type c);
      queue_result_type r;
      int pos;
      r.status = teq_pkg::ST_INSERTED;
      r.ev     = '0;
      if (c.cmd == teq_pkg::CMD_INSERT) begin
         if (sorted_events.size() >= teq_pkg::DEPTH) begin
            r.status = teq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_events.size() &&
                   {sorted_events[pos].sec, sorted_events[pos].usec} <= {c.ev.sec, c.ev.usec})
               pos++;
            sorted_events.insert(pos, c.ev);
         end
      end else begin
         if (sorted_events.size() == 0) begin
            r.status = teq_pkg::ST_EMPTY;
         end else begin
            r.status = teq_pkg::ST_POPPED;
            r.ev     = sorted_events.pop_front();
         end
      end
      r.occupancy = teq_pkg::OCC_W'(sorted_events.size());
      return r;
   endfunction

   function automatic teq_pkg::entry_type make_event(logic [31:0] sec, logic [19:0] usec,
                                                     logic [15:0] node, logic [4:0] kind,
                                                     logic [31:0] a, logic [31:0] b,
                                                     logic [31:0] c, logic [31:0] d);
      teq_pkg::entry_type e;
      e.sec  = sec;
      e.usec = usec;
      e.node = node;
      e.kind = kind;
      e.a    = a;
      e.b    = b;
      e.c    = c;
      e.d    = d;
      return e;
   endfunction

   // nearly half the stamps come from a narrow window so that ties happen often
   function automatic teq_pkg::entry_type random_event();
      teq_pkg::entry_type e;
      int pick;
      e = make_event($urandom, 20'($urandom_range(0, 999999)),
                     16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)),
                     $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         e.sec  = 32'd5000 + 32'($urandom_range(0, 3));
         e.usec = 20'($urandom_range(0, 3) * 250000);
      end else if (pick < 55) begin
         e.usec = 20'($urandom_range(1000000, 1048575));
      end else if (pick < 65) begin
         e.sec  = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
         e.usec = ($urandom_range(0, 1) == 1) ? 20'hF_FFFF : 20'h0;
      end
      return e;
   endfunction

   task automatic queue_command(teq_pkg::cmd_type c, teq_pkg::entry_type e);
      queue_command_type item;
      item.cmd = c;
      item.ev  = e;
      pending_commands.push_back(item);
      if (c == teq_pkg::CMD_INSERT && gen_fill < teq_pkg::DEPTH)
         gen_fill++;
      else if (c == teq_pkg::CMD_POP && gen_fill > 0)
         gen_fill--;
   endtask

   task automatic queue_random(int insert_pct);
      if ($urandom_range(0, 99) < insert_pct)
         queue_command(teq_pkg::CMD_INSERT, random_event());
      else
         queue_command(teq_pkg::CMD_POP, random_event());
   endtask

   // zero gaps for one stretch in every four, else mostly short gaps with a few long ones
   function automatic int pick_gap(int count);
      int r;
      if ((count / 97) % 4 == 1)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // command side
   always @(posedge clock) begin : cmd_driver
      queue_command_type item;
      int gap;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap_left <= 0;
      end else begin
         gap = send_gap_left;
         if (req_bus.valid && req_bus.ready) begin
            item.cmd = teq_pkg::cmd_type'(req_bus.cmd);
            item.ev  = make_event(req_bus.stamp_sec, req_bus.stamp_usec, req_bus.source_node,
                                  req_bus.event_kind, req_bus.word_a, req_bus.word_b,
                                  req_bus.word_c, req_bus.word_d);
            awaited_results.push_back(predict_queue_result(item));
            words_accepted++;
            gap = pick_gap(words_accepted);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the word until it is taken
         end else if (gap > 0) begin
            req_bus.valid <= 1'b0;
            gap--;
         end else if (pending_commands.size() > 0) begin
            item = pending_commands.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.cmd         <= item.cmd;
            req_bus.stamp_sec   <= item.ev.sec;
            req_bus.stamp_usec  <= item.ev.usec;
            req_bus.source_node <= item.ev.node;
            req_bus.event_kind  <= item.ev.kind;
            req_bus.word_a      <= item.ev.a;
            req_bus.word_b      <= item.ev.b;
            req_bus.word_c      <= item.ev.c;
            req_bus.word_d      <= item.ev.d;
         end else begin
            req_bus.valid <= 1'b0;
         end
         send_gap_left <= gap;
      end
   end

   // result side
   always @(posedge clock) begin : rsp_monitor
      queue_result_type seen;
      queue_result_type want;
      int stall;
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         recv_stall_left <= 0;
      end else begin
         stall = recv_stall_left;
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status    = teq_pkg::status_type'(rsp_bus.status);
            seen.ev        = make_event(rsp_bus.out_sec, rsp_bus.out_usec, rsp_bus.out_node,
                                        rsp_bus.out_kind, rsp_bus.out_a, rsp_bus.out_b,
                                        rsp_bus.out_c, rsp_bus.out_d);
            seen.occupancy = rsp_bus.occupancy;
            results_seen++;
            if (awaited_results.size() == 0) begin
               $display("%0t: result word with none expected, expected none, actual status %h",
                        $time, rsp_bus.status);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 64'(want.status), 64'(seen.status));
               check_field("out_sec", 64'(want.ev.sec), 64'(seen.ev.sec));
               check_field("out_usec", 64'(want.ev.usec), 64'(seen.ev.usec));
               check_field("out_node", 64'(want.ev.node), 64'(seen.ev.node));
               check_field("out_kind", 64'(want.ev.kind), 64'(seen.ev.kind));
               check_field("out_a", 64'(unsigned'(want.ev.a)), 64'(unsigned'(seen.ev.a)));
               check_field("out_b", 64'(unsigned'(want.ev.b)), 64'(unsigned'(seen.ev.b)));
               check_field("out_c", 64'(unsigned'(want.ev.c)), 64'(unsigned'(seen.ev.c)));
               check_field("out_d", 64'(unsigned'(want.ev.d)), 64'(unsigned'(seen.ev.d)));
               check_field("occupancy", 64'(want.occupancy), 64'(seen.occupancy));
            end
            stall = pick_gap(results_seen);
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         recv_stall_left <= stall;
      end
   end

   // one long hold-off on the result side so the queue backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_off   <= 1'b0;
         hold_done  <= 1'b0;
         hold_count <= 0;
      end else if (hold_off) begin
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_off  <= 1'b0;
            hold_done <= 1'b1;
         end
         hold_count <= hold_count + 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_off <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("time_ordered_event_queue verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;

      // directed opening
      queue_command(teq_pkg::CMD_POP, random_event());
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd100, 20'd500, 16'h0000, 5'd0,
                                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                                    32'hFFFF_FFFF));
      // same stamp again, must come out after the first
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd100, 20'd500, 16'hFFFF, 5'd31,
                                                    32'h7FFF_FFFF, 32'h8000_0000,
                                                    32'hFFFF_FFFF, 32'h0));
      // new earliest event goes to the head, the rest stays
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd0, 20'd0, 16'h1234, 5'd7,
                                                    32'h1, 32'h2, 32'h3, 32'h4));
      queue_command(teq_pkg::CMD_INSERT, make_event(32'hFFFF_FFFF, 20'hF_FFFF, 16'hA5A5, 5'd21,
                                                    32'hDEAD_BEEF, 32'hCAFE_F00D,
                                                    32'h5555_5555, 32'hAAAA_AAAA));
      // microseconds past one million, no carry into the seconds
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd99, 20'd1000000, 16'h5A5A, 5'd10,
                                                    32'h0, 32'h0, 32'h0, 32'h0));
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd100, 20'd499, 16'h0001, 5'd1,
                                                    32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                    32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_command(teq_pkg::CMD_INSERT, make_event(32'hFFFF_FFFF, 20'd999999, 16'h8000, 5'd16,
                                                    32'h8000_0000, 32'h8000_0000,
                                                    32'h8000_0000, 32'h8000_0000));
      queue_command(teq_pkg::CMD_INSERT, make_event(32'd100, 20'd500, 16'h0002, 5'd2,
                                                    32'h0, 32'h1, 32'h0, 32'h1));
      repeat (9) queue_command(teq_pkg::CMD_POP, random_event());
      queue_command(teq_pkg::CMD_POP, random_event());

      // random phases: fill past full, drain past empty, mixed traffic
      while (pending_commands.size() < RANDOM_COMMANDS + 20) begin
         case ($urandom_range(0, 3))
            0: begin
               while (gen_fill < teq_pkg::DEPTH) queue_random(90);
               repeat ($urandom_range(1, 4))
                  queue_command(teq_pkg::CMD_INSERT, random_event());
            end
            1: begin
               while (gen_fill > 0) queue_random(10);
               repeat ($urandom_range(1, 3)) queue_command(teq_pkg::CMD_POP, random_event());
            end
            2: begin
               repeat (40) queue_random(50);
            end
            default: begin
               repeat (20) queue_random(70);
            end
         endcase
      end
      total_commands = pending_commands.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < total_commands || awaited_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("time_ordered_event_queue verification clean");
      end else begin
         $display("time_ordered_event_queue verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/teq_pkg.sv
hdl/teq_if.sv
hdl/teq_ram.sv
hdl/time_ordered_event_queue.sv
tb/tb.sv
